@@ rtl/bbpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpe_pkg: shared definitions for the bicubic Bezier patch evaluator
// Field widths, the cubic Bezier basis matrix and the control word of the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bbpe_pkg;

    // Patch and field geometry
    localparam int CTRL_POINTS   = 16;
    localparam int IDX_W         = 4;
    localparam int COORD_W       = 32;
    localparam int PARAM_W       = 17;
    localparam int FRAC_BITS_DEF = 16;

    // Width of one rounded row sum (weights sum to about one, so a row stays
    // within a few bits of a coordinate)
    localparam int ROW_W = 34;

    // Entries of the 4x4 basis matrix
    localparam int BASIS_LEN = 16;

    // Bezier basis matrix, row major, applied to [t^3, t^2, t, 1]
    localparam logic signed [3:0] BASIS [BASIS_LEN] = '{
        -4'sd1,  4'sd3, -4'sd3,  4'sd1,
         4'sd3, -4'sd6,  4'sd3,  4'sd0,
        -4'sd3,  4'sd3,  4'sd0,  4'sd0,
         4'sd1,  4'sd0,  4'sd0,  4'sd0
    };

    // Control word of the multiply-accumulate unit
    typedef struct packed {
        logic en;     // update an accumulator this cycle
        logic sum;    // 0: row accumulator, 1: surface accumulator
        logic first;  // restart from the rounding offset
    } t_mac_ctl;

endpackage

@@ rtl/bbpe_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpe_mac: shared multiply-accumulate unit
// One signed multiplier feeding a row accumulator and a surface accumulator.
// Both accumulators start from half an LSB so that the rounded value is a
// plain arithmetic shift of the register.
// ----------------------------------------------------------------------------
module bbpe_mac
    import bbpe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [ROW_W-1:0]    i_op_a,
    input  logic signed [FRAC_BITS+1:0] i_op_b,
    output logic signed [ROW_W-1:0]    o_row_rnd,
    output logic signed [COORD_W-1:0]  o_sum_sat
);

    localparam int WB_W   = FRAC_BITS + 2;
    localparam int PROD_W = ROW_W + WB_W;
    localparam int ACC_W  = PROD_W + 4;

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_sum_q;
    logic signed [ACC_W-1:0]  r_row;
    logic signed [ACC_W-1:0]  n_row;
    logic signed [ACC_W-1:0]  r_sum;
    logic signed [ACC_W-1:0]  n_sum;

    // Multiply
    assign w_prod     = i_op_a * i_op_b;
    assign w_prod_ext = ACC_W'(w_prod);

    // Accumulate into the selected register
    always_comb begin
        n_row = r_row;
        n_sum = r_sum;
        if (i_ctl.en) begin
            if (!i_ctl.sum) begin
                n_row = (i_ctl.first ? HALF : r_row) + w_prod_ext;
            end else begin
                n_sum = (i_ctl.first ? HALF : r_sum) + w_prod_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_sum <= n_sum;
    end

    // Rounded row value: offset already added, drop the fraction
    assign o_row_rnd = r_row[FRAC_BITS +: ROW_W];

    // Rounded surface value, saturated to a signed coordinate
    assign w_sum_q = r_sum >>> FRAC_BITS;

    always_comb begin
        if (w_sum_q > SAT_MAX) begin
            o_sum_sat = SAT_MAX[COORD_W-1:0];
        end else if (w_sum_q < SAT_MIN) begin
            o_sum_sat = SAT_MIN[COORD_W-1:0];
        end else begin
            o_sum_sat = w_sum_q[COORD_W-1:0];
        end
    end

endmodule

@@ rtl/bicubic_bezier_patch_evaluator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_evaluator_unit: bicubic Bezier surface evaluator
// Holds 16 control points and evaluates surface points in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word per handshake.
//   i_operation = 0 writes control point i_point_index with i_point_x/y/z;
//   it yields nothing. i_operation = 1 evaluates the surface at
//   i_u_param, i_v_param (Q1.16, values above 1.0 clamp to 1.0).
//   Output channel (o_out_valid / i_out_ready) carries o_surf_x/y/z.
//   An evaluate word keeps the block busy: 4 multiplies for the powers of
//   u and v, a step for the Bernstein weights, then per coordinate 4 rows
//   of 4 column MACs plus one row MAC each, and one save step. All of it
//   runs through the single multiplier in bbpe_mac. o_in_ready rises again
//   in the same cycle that the result appears. The result sits in an output
//   register, so loads and the next evaluate proceed while it waits. If a
//   previous result is still not taken when a new one finishes, the block
//   holds in its save step until it is.
//   Reset clears the sequencer and the output valid; control point storage
//   is not cleared and a slot must be written before it is used.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_evaluator_unit
    import bbpe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_operation,
    input  logic [IDX_W-1:0]          i_point_index,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic [PARAM_W-1:0]        i_u_param,
    input  logic [PARAM_W-1:0]        i_v_param,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_surf_x,
    output logic signed [COORD_W-1:0] o_surf_y,
    output logic signed [COORD_W-1:0] o_surf_z
);

    localparam int T_W   = FRAC_BITS + 1;
    localparam int WB_W  = FRAC_BITS + 2;
    localparam int WT_W  = FRAC_BITS + 6;
    localparam int CMP_W = (PARAM_W > T_W) ? PARAM_W : T_W;

    localparam logic [T_W-1:0] ONE_T = {1'b1, {FRAC_BITS{1'b0}}};

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POW  = 3'd1;
    localparam logic [2:0] ST_WGT  = 3'd2;
    localparam logic [2:0] ST_COL  = 3'd3;
    localparam logic [2:0] ST_VROW = 3'd4;
    localparam logic [2:0] ST_SAVE = 3'd5;

    // Power steps
    localparam logic [2:0] PW_UU  = 3'd0;
    localparam logic [2:0] PW_UUU = 3'd1;
    localparam logic [2:0] PW_VV  = 3'd2;
    localparam logic [2:0] PW_VVV = 3'd3;
    localparam logic [2:0] PW_END = 3'd4;

    // Coordinate select
    localparam logic [1:0] CRD_X = 2'd0;
    localparam logic [1:0] CRD_Y = 2'd1;
    localparam logic [1:0] CRD_Z = 2'd2;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step,  n_step;
    logic [1:0] r_k, n_k;
    logic [1:0] r_r, n_r;
    logic [1:0] r_c, n_c;

    logic                 w_in_acc;
    logic                 w_load_out;
    logic [CMP_W-1:0]     w_u_ext;
    logic [CMP_W-1:0]     w_v_ext;
    logic [CMP_W-1:0]     w_one_ext;
    logic [T_W-1:0]       w_u_cl;
    logic [T_W-1:0]       w_v_cl;

    logic [T_W-1:0] r_u, r_v, r_u2, r_u3, r_v2, r_v3;

    logic signed [WT_W-1:0] w_pu [4];
    logic signed [WT_W-1:0] w_pv [4];
    logic signed [WT_W-1:0] w_wu [4];
    logic signed [WT_W-1:0] w_wv [4];
    logic signed [WB_W-1:0] r_wu [4];
    logic signed [WB_W-1:0] r_wv [4];

    logic [3*COORD_W-1:0] r_mem [CTRL_POINTS];
    logic [3*COORD_W-1:0] r_rd;
    logic [COORD_W-1:0]   w_coord;

    t_mac_ctl                   w_ctl;
    logic signed [ROW_W-1:0]    w_op_a;
    logic signed [WB_W-1:0]     w_op_b;
    logic signed [ROW_W-1:0]    w_row_rnd;
    logic signed [COORD_W-1:0]  w_sum_sat;

    logic signed [COORD_W-1:0] r_sx, r_sy;
    logic signed [COORD_W-1:0] r_out_x, r_out_y, r_out_z;
    logic                      r_out_valid;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Clamp u and v to one
    assign w_u_ext   = CMP_W'(i_u_param);
    assign w_v_ext   = CMP_W'(i_v_param);
    assign w_one_ext = CMP_W'(ONE_T);
    assign w_u_cl    = (w_u_ext > w_one_ext) ? ONE_T : w_u_ext[T_W-1:0];
    assign w_v_cl    = (w_v_ext > w_one_ext) ? ONE_T : w_v_ext[T_W-1:0];

    // Control point store: write on load, read the next slot every cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !i_operation) begin
            r_mem[i_point_index] <= {i_point_x, i_point_y, i_point_z};
        end
        r_rd <= r_mem[{n_r, n_c}];
    end

    // Pick the coordinate being summed
    always_comb begin
        case (r_k)
            CRD_X:   w_coord = r_rd[3*COORD_W-1:2*COORD_W];
            CRD_Y:   w_coord = r_rd[2*COORD_W-1:COORD_W];
            CRD_Z:   w_coord = r_rd[COORD_W-1:0];
            default: w_coord = r_rd[COORD_W-1:0];
        endcase
    end

    // Bernstein weights from the power vectors [t^3, t^2, t, 1]
    always_comb begin
        w_pu[0] = $signed(WT_W'(r_u3));
        w_pu[1] = $signed(WT_W'(r_u2));
        w_pu[2] = $signed(WT_W'(r_u));
        w_pu[3] = $signed(WT_W'(ONE_T));
        w_pv[0] = $signed(WT_W'(r_v3));
        w_pv[1] = $signed(WT_W'(r_v2));
        w_pv[2] = $signed(WT_W'(r_v));
        w_pv[3] = $signed(WT_W'(ONE_T));
        for (int j = 0; j < 4; j++) begin
            w_wu[j] = '0;
            w_wv[j] = '0;
            for (int k = 0; k < 4; k++) begin
                w_wu[j] = w_wu[j] + WT_W'(BASIS[j*4+k]) * w_pu[k];
                w_wv[j] = w_wv[j] + WT_W'(BASIS[j*4+k]) * w_pv[k];
            end
        end
    end

    // Sequencer and operand selection
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_k        = r_k;
        n_r        = r_r;
        n_c        = r_c;
        w_ctl      = '0;
        w_op_a     = '0;
        w_op_b     = '0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_operation) begin
                    n_state = ST_POW;
                    n_step  = PW_UU;
                end
            end
            ST_POW: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    PW_UU: begin
                        w_ctl  = '{en: 1'b1, sum: 1'b0, first: 1'b1};
                        w_op_a = $signed(ROW_W'(r_u));
                        w_op_b = $signed({1'b0, r_u});
                    end
                    PW_UUU: begin
                        w_ctl  = '{en: 1'b1, sum: 1'b0, first: 1'b1};
                        w_op_a = w_row_rnd;
                        w_op_b = $signed({1'b0, r_u});
                    end
                    PW_VV: begin
                        w_ctl  = '{en: 1'b1, sum: 1'b0, first: 1'b1};
                        w_op_a = $signed(ROW_W'(r_v));
                        w_op_b = $signed({1'b0, r_v});
                    end
                    PW_VVV: begin
                        w_ctl  = '{en: 1'b1, sum: 1'b0, first: 1'b1};
                        w_op_a = w_row_rnd;
                        w_op_b = $signed({1'b0, r_v});
                    end
                    PW_END: begin
                        n_state = ST_WGT;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_WGT: begin
                n_state = ST_COL;
                n_k     = CRD_X;
                n_r     = 2'd0;
                n_c     = 2'd0;
            end
            ST_COL: begin
                w_ctl  = '{en: 1'b1, sum: 1'b0, first: (r_c == 2'd0)};
                w_op_a = $signed({{(ROW_W-COORD_W){w_coord[COORD_W-1]}}, w_coord});
                w_op_b = r_wu[r_c];
                n_c    = r_c + 2'd1;
                if (r_c == 2'd3) begin
                    n_state = ST_VROW;
                end
            end
            ST_VROW: begin
                w_ctl  = '{en: 1'b1, sum: 1'b1, first: (r_r == 2'd0)};
                w_op_a = w_row_rnd;
                w_op_b = r_wv[r_r];
                n_r    = r_r + 2'd1;
                n_c    = 2'd0;
                n_state = (r_r == 2'd3) ? ST_SAVE : ST_COL;
            end
            ST_SAVE: begin
                if (r_k != CRD_Z) begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_COL;
                end else if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= PW_UU;
            r_k         <= CRD_X;
            r_r         <= 2'd0;
            r_c         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_k     <= n_k;
            r_r     <= n_r;
            r_c     <= n_c;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: parameters, powers, weights, results
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_operation) begin
            r_u <= w_u_cl;
            r_v <= w_v_cl;
        end
        if (r_state == ST_POW) begin
            case (r_step)
                PW_UUU:  r_u2 <= w_row_rnd[T_W-1:0];
                PW_VV:   r_u3 <= w_row_rnd[T_W-1:0];
                PW_VVV:  r_v2 <= w_row_rnd[T_W-1:0];
                PW_END:  r_v3 <= w_row_rnd[T_W-1:0];
                default: r_u2 <= r_u2;
            endcase
        end
        if (r_state == ST_WGT) begin
            for (int j = 0; j < 4; j++) begin
                r_wu[j] <= w_wu[j][WB_W-1:0];
                r_wv[j] <= w_wv[j][WB_W-1:0];
            end
        end
        if (r_state == ST_SAVE) begin
            if (r_k == CRD_X) begin
                r_sx <= w_sum_sat;
            end
            if (r_k == CRD_Y) begin
                r_sy <= w_sum_sat;
            end
        end
        if (w_load_out) begin
            r_out_x <= r_sx;
            r_out_y <= r_sy;
            r_out_z <= w_sum_sat;
        end
    end

    bbpe_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_op_a    (w_op_a),
        .i_op_b    (w_op_b),
        .o_row_rnd (w_row_rnd),
        .o_sum_sat (w_sum_sat)
    );

    assign o_out_valid = r_out_valid;
    assign o_surf_x    = r_out_x;
    assign o_surf_y    = r_out_y;
    assign o_surf_z    = r_out_z;

    // Evaluate word starts the power steps
    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_operation) |=> (r_state == ST_POW && r_step == PW_UU))
        else $error("evaluate word did not start the power steps");

    // Load word never raises the result valid
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_operation && !r_out_valid) |=> !r_out_valid)
        else $error("load word produced a result");

    // Result appears only from the last save step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_SAVE && r_k == CRD_Z))
        else $error("result valid rose outside the final save step");

    // Coordinate counter stays within x, y, z while summing
    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COL || r_state == ST_VROW || r_state == ST_SAVE)
            |-> (r_k != 2'd3))
        else $error("coordinate counter out of range");

endmodule

@@ sim/tb_bicubic_bezier_patch_evaluator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bicubic_bezier_patch_evaluator_unit: self-checking bench for the patch evaluator
// Loads the 16 control points, then drives directed and random load and
// evaluate words with random gaps on both channels and one long output
// stall. Each surface point is checked against an in-bench fixed point
// Bezier evaluation computed when the evaluate word is taken.
// ----------------------------------------------------------------------------
module tb_bicubic_bezier_patch_evaluator_unit
    import bbpe_pkg::*;
();

    // Operation codes of an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Fixed point constants
    localparam int     FRAC_Q = FRAC_BITS_DEF;
    localparam longint ONE_Q  = longint'(1) <<< FRAC_Q;
    localparam longint HALF_Q = longint'(1) <<< (FRAC_Q - 1);
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam logic [PARAM_W-1:0] PARAM_ONE = 17'd65536;
    localparam logic [PARAM_W-1:0] PARAM_MAX = 17'h1FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Run shape
    localparam int RANDOM_WORDS     = 1010;
    localparam int PHASE_WORDS      = 100;
    localparam int STALL_BURST      = 12;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 100;
    localparam int CYCLE_LIMIT      = 1_000_000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_surf_point;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_operation;
    logic [IDX_W-1:0]          i_point_index;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic signed [COORD_W-1:0] i_point_z;
    logic [PARAM_W-1:0]        i_u_param;
    logic [PARAM_W-1:0]        i_v_param;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [COORD_W-1:0] o_surf_x;
    logic signed [COORD_W-1:0] o_surf_y;
    logic signed [COORD_W-1:0] o_surf_z;

    // Bench copy of the control points and the surface points still owed
    logic signed [COORD_W-1:0] patch_store [CTRL_POINTS][3];
    t_surf_point               pending_points [$];
    t_surf_point               point_due;

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;
    bit          sink_hold_req = 1'b0;
    int          sink_hold_left = 0;
    int          sink_gap_left = 0;

    bicubic_bezier_patch_evaluator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_u_param     (i_u_param),
        .i_v_param     (i_v_param),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_surf_x      (o_surf_x),
        .o_surf_y      (o_surf_y),
        .o_surf_z      (o_surf_z)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_bicubic_bezier_patch_evaluator_unit NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Fixed point surface evaluation
    // ------------------------------------------------------------------

    // Round half up by one fraction width
    function automatic longint round_q(input longint a);
        return (a + HALF_Q) >>> FRAC_Q;
    endfunction

    // Bernstein weight j of a parameter, clamped to one
    function automatic longint bezier_weight(input logic [PARAM_W-1:0] raw, input int j);
        longint t, t2, t3;
        t = raw;
        if (t > ONE_Q) begin
            t = ONE_Q;
        end
        t2 = round_q(t * t);
        t3 = round_q(t2 * t);
        case (j)
            0:       return -t3 + 3 * t2 - 3 * t + ONE_Q;
            1:       return 3 * t3 - 6 * t2 + 3 * t;
            2:       return -3 * t3 + 3 * t2;
            default: return t3;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] clip32(input longint a);
        if (a > SAT_HI) begin
            return COORD_MAX;
        end
        if (a < SAT_LO) begin
            return COORD_MIN;
        end
        return a[COORD_W-1:0];
    endfunction

    // Weight each row by u across its columns, then the rows by v
    function automatic t_surf_point evaluate_surface(input logic [PARAM_W-1:0] u,
                                                     input logic [PARAM_W-1:0] v);
        longint wu [4];
        longint wv [4];
        longint row, acc;
        logic [COORD_W-1:0] axis_val [3];
        int r, c, a;
        for (c = 0; c < 4; c++) begin
            wu[c] = bezier_weight(u, c);
            wv[c] = bezier_weight(v, c);
        end
        for (a = 0; a < 3; a++) begin
            acc = 0;
            for (r = 0; r < 4; r++) begin
                row = 0;
                for (c = 0; c < 4; c++) begin
                    row += wu[c] * longint'(patch_store[r * 4 + c][a]);
                end
                acc += round_q(row) * wv[r];
            end
            axis_val[a] = clip32(round_q(acc));
        end
        return '{x: axis_val[0], y: axis_val[1], z: axis_val[2]};
    endfunction

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(5, 90);
    endfunction

    // Mostly moderate coordinates, some full range, some extremes
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return $urandom;
            default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
    endfunction

    // Mostly inside [0, 1], with the ends and some values to be clamped
    function automatic logic [PARAM_W-1:0] rand_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 10) begin
            return PARAM_ONE;
        end else if (r < 20) begin
            return PARAM_W'($urandom_range(65537, 131071));
        end
        return PARAM_W'($urandom_range(0, 65536));
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word and hold it until taken; update the bench state on the take
    task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic signed [COORD_W-1:0] pz,
                             input logic [PARAM_W-1:0] u, input logic [PARAM_W-1:0] v);
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_point_index <= idx;
        i_point_x     <= px;
        i_point_y     <= py;
        i_point_z     <= pz;
        i_u_param     <= u;
        i_v_param     <= v;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (op == OP_LOAD) begin
            patch_store[idx][0] = px;
            patch_store[idx][1] = py;
            patch_store[idx][2] = pz;
        end else begin
            pending_points.insert(pending_points.size(), evaluate_surface(u, v));
        end
    endtask

    // Drop valid for a random gap unless the source runs calm
    task automatic source_pause();
        int n;
        n = src_calm ? 0 : gap_len();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Drive ready: long hold on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_hold_left <= SINK_HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left <= sink_hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (sink_gap_left > 0) begin
            sink_gap_left <= sink_gap_left - 1;
            i_out_ready <= 1'b0;
        end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            sink_gap_left <= gap_len();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_coord(input string axis, input logic signed [COORD_W-1:0] want,
                               input logic signed [COORD_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: surf_%s mismatch: expected %0d, actual %0d", $time, axis, want, got);
        end
    endtask

    // Compare each taken result with the oldest owed point
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %0d %0d %0d",
                         $time, o_surf_x, o_surf_y, o_surf_z);
            end else begin
                point_due = pending_points.pop_front();
                check_coord("x", point_due.x, o_surf_x);
                check_coord("y", point_due.y, o_surf_y);
                check_coord("z", point_due.z, o_surf_z);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill every slot before any evaluate: checkerboard of x extremes,
    // ramp in y, random z, parameter fields set to garbage
    task automatic test_load_patch();
        int i;
        for (i = 0; i < CTRL_POINTS; i++) begin
            send_word(OP_LOAD, i[IDX_W-1:0],
                      ((i + i / 4) % 2 == 0) ? COORD_MAX : COORD_MIN,
                      (i * 3 - 20) <<< 16, $urandom,
                      (i % 2 == 0) ? PARAM_MAX : '0, (i % 3 == 0) ? PARAM_MAX : '0);
            source_pause();
        end
    endtask

    // Corners return the corner control points; point fields are ignored
    task automatic test_corners();
        send_word(OP_EVAL, 4'hF, $urandom, $urandom, $urandom, '0, '0);
        source_pause();
        send_word(OP_EVAL, 4'h0, $urandom, $urandom, $urandom, PARAM_ONE, '0);
        source_pause();
        send_word(OP_EVAL, 4'hA, $urandom, $urandom, $urandom, '0, PARAM_ONE);
        source_pause();
        send_word(OP_EVAL, 4'h5, $urandom, $urandom, $urandom, PARAM_ONE, PARAM_ONE);
        source_pause();
    endtask

    // Parameters above one clamp; midpoint for contrast
    task automatic test_param_clamp();
        send_word(OP_EVAL, '0, '0, '0, '0, 17'd65537, PARAM_MAX);
        source_pause();
        send_word(OP_EVAL, '0, '0, '0, '0, PARAM_MAX, '0);
        source_pause();
        send_word(OP_EVAL, '1, '1, '1, '1, 17'd32768, 17'd32768);
        source_pause();
    endtask

    // A load with parameter bits set changes only its slot
    task automatic test_load_ignores_params();
        send_word(OP_LOAD, 4'd5, rand_coord(), rand_coord(), rand_coord(), PARAM_MAX, PARAM_MAX);
        source_pause();
        send_word(OP_EVAL, '0, '0, '0, '0, 17'd21845, 17'd43690);
        source_pause();
    endtask

    // Hold the output off while evaluates keep coming so the input stalls
    task automatic test_backpressure();
        int i;
        sink_hold_req = 1'b1;
        src_calm = 1'b1;
        for (i = 0; i < STALL_BURST; i++) begin
            send_word(OP_EVAL, IDX_W'($urandom), $urandom, $urandom, $urandom,
                      rand_param(), rand_param());
        end
        src_calm = 1'b0;
    endtask

    // Random loads and evaluates; every slot already holds a point
    task automatic test_random_mix();
        int n;
        logic op;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_WORDS == 0) begin
                src_calm  = ($urandom_range(0, 3) == 0);
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_EVAL;
            send_word(op, IDX_W'($urandom_range(0, 15)), rand_coord(), rand_coord(),
                      rand_coord(), rand_param(), rand_param());
            source_pause();
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_LOAD;
        i_point_index = '0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_point_z     = '0;
        i_u_param     = '0;
        i_v_param     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_load_patch();
        test_corners();
        test_param_clamp();
        test_load_ignores_params();
        test_backpressure();
        test_random_mix();
        i_in_valid <= 1'b0;

        // Drain owed points, then watch for strays
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_bicubic_bezier_patch_evaluator_unit OK");
        end else begin
            $display("tb_bicubic_bezier_patch_evaluator_unit NOT OK");
        end
        $finish;
    end

endmodule
